[design/qpr_pkg.sv]
package qpr_pkg;

   localparam int CordicSteps = 24;
   localparam int StepW = $clog2(CordicSteps + 1);

   // Command codes carried in tuser.
   typedef enum logic [2:0] {
      CMD_PRODUCT  = 3'd0,
      CMD_PREMUL   = 3'd1,
      CMD_POSTMUL  = 3'd2,
      CMD_MAKE_ROT = 3'd3,
      CMD_PREROT   = 3'd4,
      CMD_POSTROT  = 3'd5
   } cmd_type;

   typedef logic signed [31:0] comp_type;
   typedef comp_type [3:0] quat_type;   // index 0 x, 1 y, 2 z, 3 w

   localparam logic signed [33:0] HalfPi = 34'sd1686629713;
   localparam logic signed [33:0] Pi     = 34'sd3373259426;
   localparam logic signed [33:0] Gain   = 34'sd652032874;
   localparam logic signed [31:0] OneQ30 = 32'sd1073741824;

   // Arctangent of 2^-i in Q.30, floored.
   function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
      logic signed [33:0] r;
      case (i)
         5'd0: r = 34'sd843314856;   5'd1: r = 34'sd497837829;
         5'd2: r = 34'sd263043836;   5'd3: r = 34'sd133525158;
         5'd4: r = 34'sd67021686;    5'd5: r = 34'sd33543515;
         5'd6: r = 34'sd16775850;    5'd7: r = 34'sd8388437;
         5'd8: r = 34'sd4194282;     5'd9: r = 34'sd2097149;
         5'd10: r = 34'sd1048575;    5'd11: r = 34'sd524287;
         5'd12: r = 34'sd262143;     5'd13: r = 34'sd131071;
         5'd14: r = 34'sd65535;      5'd15: r = 34'sd32767;
         5'd16: r = 34'sd16383;      5'd17: r = 34'sd8191;
         5'd18: r = 34'sd4095;       5'd19: r = 34'sd2047;
         5'd20: r = 34'sd1023;       5'd21: r = 34'sd511;
         5'd22: r = 34'sd255;        5'd23: r = 34'sd127;
         5'd24: r = 34'sd63;         5'd25: r = 34'sd31;
         5'd26: r = 34'sd15;         5'd27: r = 34'sd7;
         5'd28: r = 34'sd3;          5'd29: r = 34'sd1;
         default: r = 34'sd0;
      endcase
      return r;
   endfunction

   // Round a Q6.60 sum to Q2.30 and clip to 32 bits.
   function automatic logic [32:0] round_sat(input logic signed [65:0] v);
      logic signed [65:0] t;
      logic signed [35:0] h;
      t = v + 66'sd536870912;
      h = t[65:30];
      if (h > 36'sd2147483647) return {1'b1, 32'h7FFFFFFF};
      if (h < -36'sd2147483648) return {1'b1, 32'h80000000};
      return {1'b0, h[31:0]};
   endfunction

endpackage

[design/qpr_cordic.sv]
module qpr_cordic (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic signed [31:0] angle,
   output logic done,
   output logic signed [31:0] sin_val,
   output logic signed [31:0] cos_val
);
   import qpr_pkg::*;

   logic signed [33:0] x_ff, y_ff, z_ff;
   logic [StepW-1:0] i_ff;
   logic busy_ff, flip_ff, done_ff;
   logic signed [33:0] z0, xs, ys, at;

   assign at = atan_entry(5'(i_ff));
   assign xs = x_ff >>> i_ff;
   assign ys = y_ff >>> i_ff;

   // Range reduction of the half angle into [-pi/2, pi/2].
   always_comb begin
      z0 = 34'(angle) <<< 1;
      if (z0 > HalfPi) z0 = z0 - Pi;
      else if (z0 < -HalfPi) z0 = z0 + Pi;
   end

   // One micro-rotation per cycle.
   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         i_ff <= '0;
         x_ff <= Gain;
         y_ff <= '0;
         z_ff <= z0;
         flip_ff <= (34'(angle) <<< 1) > HalfPi || (34'(angle) <<< 1) < -HalfPi;
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_ff <= x_ff - ys; y_ff <= y_ff + xs; z_ff <= z_ff - at;
         end else begin
            x_ff <= x_ff + ys; y_ff <= y_ff - xs; z_ff <= z_ff + at;
         end
         i_ff <= i_ff + 1'b1;
         if (i_ff == StepW'(CordicSteps - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign sin_val = flip_ff ? -y_ff[31:0] : y_ff[31:0];
   assign cos_val = flip_ff ? -x_ff[31:0] : x_ff[31:0];
endmodule

[design/qpr_lane.sv]
module qpr_lane (
   input  logic clock,
   input  logic signed [31:0] p [4],
   input  logic signed [31:0] q [4],
   input  logic [3:0] neg,
   input  logic [1:0] sel,
   input  logic clr,
   input  logic en,
   output logic signed [65:0] acc
);
   import qpr_pkg::*;

   logic signed [63:0] prod_ff;
   logic neg_ff, en_ff, clr_ff;
   logic signed [65:0] acc_ff;

   // One product per cycle, then accumulate; a clear that meets the first
   // product loads that product instead of dropping it.
   always_ff @(posedge clock) begin
      prod_ff <= p[sel] * q[sel];
      neg_ff <= neg[sel];
      en_ff <= en;
      clr_ff <= clr;
      if (clr_ff) acc_ff <= en_ff ? (neg_ff ? -66'(prod_ff) : 66'(prod_ff)) : '0;
      else if (en_ff) acc_ff <= neg_ff ? acc_ff - 66'(prod_ff) : acc_ff + 66'(prod_ff);
   end
   assign acc = acc_ff;
endmodule

[design/quaternion_product_and_rotate_top.sv]
// Channel  | Ports         | Payload
// request  | req_t*        | tdata 8 x 32 (a_x..b_w), angle; tuser cmd
// response | rsp_t*        | tdata q_x..q_w; tuser saturated
// After acceptance, a product runs one Hamilton product pass; a plain rotation runs
// 24 CORDIC steps on one shared unit, hands over, then runs the axis scaling pass;
// pre- and post-rotation add a product pass. Unused commands go straight to the
// response. The next request is taken once the response has been registered.
// Four lanes, one per output component, each run one multiplier over four terms.
// Reset is synchronous and restores the identity orientation.
// A held response lets one more request through; that one then waits until the
// held response is taken, and no further request is accepted meanwhile.
module quaternion_product_and_rotate_top (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, turn_angle
   input  logic [287:0] req_tdata,
   // cmd
   input  logic [2:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // q_x, q_y, q_z, q_w
   output logic [127:0] rsp_tdata,
   // saturated
   output logic rsp_tuser
);
   import qpr_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001, S_CORD = 6'b000010, S_AXIS = 6'b000100,
      S_HAM = 6'b001000, S_FIN = 6'b010000, S_OUT = 6'b100000
   } state_type;

   state_type st_ff;
   quat_type st_q_ff, a_ff, l_ff, r_ff;
   logic [2:0] cmd_ff;
   logic [2:0] cnt_ff;
   logic sat_ff;
   logic [127:0] out_ff;
   logic outsat_ff, ov_ff;
   logic cstart, cdone;
   logic signed [31:0] s_v, c_v;
   logic signed [31:0] lp [4][4], lq [4][4];
   logic [3:0] lneg [4];
   logic signed [65:0] acc [4];
   logic axis_mode;
   logic [32:0] rs [4];

   assign req_tready = (st_ff == S_IDLE);
   assign cstart = req_tvalid && req_tready;

   qpr_cordic u_cordic (.clock, .reset, .start(st_ff == S_IDLE && cstart),
      .angle(req_tdata[287:256]), .done(cdone), .sin_val(s_v), .cos_val(c_v));

   // Term tables of the Hamilton product, or one axis*sine term.
   always_comb begin
      axis_mode = (st_ff == S_AXIS);
      for (int k = 0; k < 4; k++) begin
         for (int j = 0; j < 4; j++) begin
            lp[k][j] = axis_mode ? (j == 0 ? a_ff[k] : 32'sd0) : 32'sd0;
            lq[k][j] = axis_mode ? (j == 0 ? s_v : 32'sd0) : 32'sd0;
         end
         lneg[k] = 4'b0;
      end
      if (!axis_mode) begin
         lp[0] = '{l_ff[3], l_ff[0], l_ff[1], l_ff[2]};
         lq[0] = '{r_ff[0], r_ff[3], r_ff[2], r_ff[1]}; lneg[0] = 4'b1000;
         lp[1] = '{l_ff[3], l_ff[0], l_ff[1], l_ff[2]};
         lq[1] = '{r_ff[1], r_ff[2], r_ff[3], r_ff[0]}; lneg[1] = 4'b0010;
         lp[2] = '{l_ff[3], l_ff[0], l_ff[1], l_ff[2]};
         lq[2] = '{r_ff[2], r_ff[1], r_ff[0], r_ff[3]}; lneg[2] = 4'b0100;
         lp[3] = '{l_ff[3], l_ff[0], l_ff[1], l_ff[2]};
         lq[3] = '{r_ff[3], r_ff[0], r_ff[1], r_ff[2]}; lneg[3] = 4'b1110;
      end
   end

   genvar g;
   generate
      for (g = 0; g < 4; g++) begin : g_lane
         qpr_lane u_lane (.clock, .p(lp[g]), .q(lq[g]), .neg(lneg[g]),
            .sel(cnt_ff[1:0]), .clr(cnt_ff == 3'd0 && st_ff != S_FIN),
            .en((st_ff == S_HAM && !cnt_ff[2]) || (st_ff == S_AXIS && cnt_ff == 3'd0)),
            .acc(acc[g]));
         assign rs[g] = round_sat(acc[g]);
      end
   endgenerate

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         ov_ff <= 1'b0;
         st_q_ff <= '{OneQ30, 32'sd0, 32'sd0, 32'sd0};
      end else begin
         if (ov_ff && rsp_tready) ov_ff <= 1'b0;
         unique case (st_ff)
            S_IDLE: if (cstart) begin
               for (int k = 0; k < 4; k++) begin
                  a_ff[k] <= req_tdata[32*k +: 32];
               end
               cmd_ff <= req_tuser; sat_ff <= 1'b0; cnt_ff <= '0;
               unique case (req_tuser)
                  CMD_PRODUCT: begin
                     for (int k = 0; k < 4; k++) begin
                        l_ff[k] <= req_tdata[32*k +: 32];
                        r_ff[k] <= req_tdata[128 + 32*k +: 32];
                     end
                     st_ff <= S_HAM;
                  end
                  CMD_PREMUL: begin
                     for (int k = 0; k < 4; k++) l_ff[k] <= req_tdata[32*k +: 32];
                     r_ff <= st_q_ff; st_ff <= S_HAM;
                  end
                  CMD_POSTMUL: begin
                     for (int k = 0; k < 4; k++) r_ff[k] <= req_tdata[32*k +: 32];
                     l_ff <= st_q_ff; st_ff <= S_HAM;
                  end
                  CMD_MAKE_ROT, CMD_PREROT, CMD_POSTROT: st_ff <= S_CORD;
                  default: st_ff <= S_OUT;
               endcase
            end
            S_CORD: if (cdone) st_ff <= S_AXIS;
            S_AXIS: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 3'd3) begin
                  for (int k = 0; k < 3; k++) r_ff[k] <= rs[k][31:0];
                  r_ff[3] <= c_v;
                  sat_ff <= rs[0][32] | rs[1][32] | rs[2][32];
                  cnt_ff <= '0;
                  if (cmd_ff == CMD_PREROT) begin
                     for (int k = 0; k < 3; k++) l_ff[k] <= rs[k][31:0];
                     l_ff[3] <= c_v; r_ff <= st_q_ff; st_ff <= S_HAM;
                  end else if (cmd_ff == CMD_POSTROT) begin
                     l_ff <= st_q_ff; st_ff <= S_HAM;
                  end else begin
                     st_ff <= S_OUT;
                  end
               end
            end
            S_HAM: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 3'd6) st_ff <= S_FIN;
            end
            S_FIN: begin
               for (int k = 0; k < 4; k++) r_ff[k] <= rs[k][31:0];
               sat_ff <= sat_ff | rs[0][32] | rs[1][32] | rs[2][32] | rs[3][32];
               st_ff <= S_OUT;
            end
            S_OUT: if (!ov_ff || rsp_tready) begin
               if (cmd_ff <= CMD_POSTROT) begin
                  st_q_ff <= r_ff;
                  out_ff <= r_ff;
               end else begin
                  out_ff <= st_q_ff;
               end
               outsat_ff <= (cmd_ff <= CMD_POSTROT) ? sat_ff : 1'b0;
               ov_ff <= 1'b1;
               st_ff <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata = out_ff;
   assign rsp_tuser = outsat_ff;
endmodule

[sim/quaternion_product_and_rotate_top_tb.sv]
`timescale 1ns / 1ps

module quaternion_product_and_rotate_top_tb;
   import qpr_pkg::*;

   localparam int RandomRequests = 1800;
   localparam int CycleLimit = 2000000;
   localparam logic [31:0] MaxPos = 32'h7FFFFFFF;
   localparam logic [31:0] MaxNeg = 32'h80000000;
   localparam logic [31:0] One = 32'h40000000;
   localparam logic [31:0] MinusOne = 32'hC0000000;
   // Codes left unused by the block; they must leave the orientation alone.
   localparam logic [2:0] CmdSpare6 = 3'd6;
   localparam logic [2:0] CmdSpare7 = 3'd7;

   typedef struct packed {
      logic [2:0] cmd;
      logic [31:0] angle;
      logic [31:0] bw, bz, by, bx, aw, az, ay, ax;
   } request_type;

   typedef struct packed {
      logic sat;
      logic [31:0] w, z, y, x;
   } orient_type;

   // One row of the directed table; known marks a result read off at a glance.
   typedef struct {
      request_type req;
      logic known;
      orient_type result;
   } row_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [287:0] req_tdata;
   logic [2:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [127:0] rsp_tdata;
   logic rsp_tuser;

   orient_type expected_orients[$];
   orient_type table_results[$];
   logic table_known[$];
   logic signed [31:0] orient_x, orient_y, orient_z, orient_w;
   int errors;
   int cycles;
   logic calm;
   logic hold_rsp;

   quaternion_product_and_rotate_top i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Round a Q6.60 sum to Q2.30 and clip; flags clipping in sat.
   function automatic logic [31:0] round_clip(input logic signed [65:0] sum, inout logic sat);
      logic signed [65:0] t;
      t = (sum + 66'sd536870912) >>> 30;
      if (t > 66'sd2147483647) begin
         sat = 1'b1;
         return MaxPos;
      end
      if (t < -66'sd2147483648) begin
         sat = 1'b1;
         return MaxNeg;
      end
      return t[31:0];
   endfunction

   function automatic logic signed [65:0] mul(input logic signed [31:0] p,
                                              input logic signed [31:0] q);
      return 66'(p) * 66'(q);
   endfunction

   // Hamilton product l*r, components in order x, y, z, w.
   function automatic void hamilton_product(input logic signed [31:0] l[4],
                                            input logic signed [31:0] r[4],
                                            output logic signed [31:0] o[4],
                                            inout logic sat);
      o[0] = round_clip(mul(l[3], r[0]) + mul(l[0], r[3]) + mul(l[1], r[2])
                        - mul(l[2], r[1]), sat);
      o[1] = round_clip(mul(l[3], r[1]) - mul(l[0], r[2]) + mul(l[1], r[3])
                        + mul(l[2], r[0]), sat);
      o[2] = round_clip(mul(l[3], r[2]) + mul(l[0], r[1]) - mul(l[1], r[0])
                        + mul(l[2], r[3]), sat);
      o[3] = round_clip(mul(l[3], r[3]) - mul(l[0], r[0]) - mul(l[1], r[1])
                        - mul(l[2], r[2]), sat);
   endfunction

   // Axis-angle quaternion; sine and cosine of the half angle by fixed CORDIC.
   function automatic void rotation_quat(input logic signed [31:0] axis[4],
                                         input logic signed [31:0] angle,
                                         output logic signed [31:0] o[4],
                                         inout logic sat);
      logic signed [63:0] z, x, y, nx;
      logic flip;
      z = 64'(angle) * 2;
      x = 64'(Gain);
      y = 0;
      flip = 1'b0;
      if (z > 64'(HalfPi)) begin
         z -= 64'(Pi);
         flip = 1'b1;
      end else if (z < -64'(HalfPi)) begin
         z += 64'(Pi);
         flip = 1'b1;
      end
      for (int i = 0; i < CordicSteps; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= 64'(atan_entry(5'(i)));
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += 64'(atan_entry(5'(i)));
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      for (int k = 0; k < 3; k++) o[k] = round_clip(mul(axis[k], y[31:0]), sat);
      o[3] = x[31:0];
   endfunction

   // Apply one request to the orientation and return the new one.
   function automatic orient_type apply_request(input request_type r);
      logic signed [31:0] a[4], b[4], cur[4], rot[4], n[4];
      logic sat;
      orient_type res;
      sat = 1'b0;
      a = '{r.ax, r.ay, r.az, r.aw};
      b = '{r.bx, r.by, r.bz, r.bw};
      cur = '{orient_x, orient_y, orient_z, orient_w};
      n = cur;
      case (r.cmd)
         CMD_PRODUCT: hamilton_product(a, b, n, sat);
         CMD_PREMUL: hamilton_product(a, cur, n, sat);
         CMD_POSTMUL: hamilton_product(cur, a, n, sat);
         CMD_MAKE_ROT: rotation_quat(a, r.angle, n, sat);
         CMD_PREROT: begin
            rotation_quat(a, r.angle, rot, sat);
            hamilton_product(rot, cur, n, sat);
         end
         CMD_POSTROT: begin
            rotation_quat(a, r.angle, rot, sat);
            hamilton_product(cur, rot, n, sat);
         end
         default: ;
      endcase
      orient_x = n[0];
      orient_y = n[1];
      orient_z = n[2];
      orient_w = n[3];
      res = '{sat, n[3], n[2], n[1], n[0]};
      return res;
   endfunction

   function automatic logic [31:0] random_comp();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? MaxPos : MaxNeg;
         default: return 32'($signed($urandom_range(0, 32'h7FFFFFFF)) - 32'sh40000000) >>> 1;
      endcase
   endfunction

   function automatic request_type random_request();
      request_type r;
      r.cmd = ($urandom_range(0, 29) == 0) ? 3'($urandom_range(6, 7))
                                             : 3'($urandom_range(0, 5));
      r.ax = random_comp();
      r.ay = random_comp();
      r.az = random_comp();
      r.aw = random_comp();
      r.bx = random_comp();
      r.by = random_comp();
      r.bz = random_comp();
      r.bw = random_comp();
      r.angle = $urandom();
      // Renormalize now and then with a near-unit rotation so the state stays alive.
      if ($urandom_range(0, 3) == 0) begin
         r.cmd = CMD_MAKE_ROT;
         r.ax = One;
         r.ay = 0;
         r.az = 0;
      end
      return r;
   endfunction

   function automatic request_type make_req(input logic [2:0] cmd, input logic [31:0] ax,
                                            input logic [31:0] ay, input logic [31:0] az,
                                            input logic [31:0] aw, input logic [31:0] bx,
                                            input logic [31:0] by, input logic [31:0] bz,
                                            input logic [31:0] bw, input logic [31:0] ang);
      request_type r;
      r = '{cmd, ang, bw, bz, by, bx, aw, az, ay, ax};
      return r;
   endfunction

   // Offer one request and wait until it is taken.
   task automatic send_request(input request_type r, input logic has_known,
                               input orient_type known_result);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(1, 15);
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= r.cmd;
      req_tdata <= {r.angle, r.bw, r.bz, r.by, r.bx, r.aw, r.az, r.ay, r.ax};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_orients.push_back(apply_request(r));
      table_known.push_back(has_known);
      table_results.push_back(known_result);
      @(negedge clock);
   endtask

   // Compare each response with the oldest expectation.
   always @(posedge clock) begin
      orient_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata};
         if (expected_orients.size() == 0) begin
            $error("response with no request outstanding: %h", got);
            errors++;
         end else begin
            want = expected_orients.pop_front();
            if (table_known.pop_front()) begin
               if (table_results.pop_front() != want) begin
                  $error("table entry disagrees with predictor");
                  errors++;
               end
            end else begin
               void'(table_results.pop_front());
            end
            if (got.x !== want.x) begin
               $error("q_x expected %h actual %h", want.x, got.x);
               errors++;
            end
            if (got.y !== want.y) begin
               $error("q_y expected %h actual %h", want.y, got.y);
               errors++;
            end
            if (got.z !== want.z) begin
               $error("q_z expected %h actual %h", want.z, got.z);
               errors++;
            end
            if (got.w !== want.w) begin
               $error("q_w expected %h actual %h", want.w, got.w);
               errors++;
            end
            if (got.sat !== want.sat) begin
               $error("saturated expected %b actual %b", want.sat, got.sat);
               errors++;
            end
         end
      end
   end

   // Response side: random stall bursts, plus one long hold-off on request.
   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            gap = $urandom_range(1, 15);
            repeat (gap) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            gap = $urandom_range(1, 20);
            repeat (gap) @(negedge clock);
         end
      end
   end

   // Watchdog.
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CycleLimit) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      row_type rows[$];
      orient_type ident;
      int wait_cycles;
      errors = 0;
      calm = 1'b0;
      hold_rsp = 1'b0;
      orient_x = 0;
      orient_y = 0;
      orient_z = 0;
      orient_w = One;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      ident = '{1'b0, One, 32'd0, 32'd0, 32'd0};

      // Directed table: identity checks, extremes, every command, spare codes.
      rows.push_back('{make_req(CmdSpare6, MaxPos, MaxNeg, MaxPos, MaxNeg, MaxPos, MaxNeg,
                                MaxPos, MaxNeg, MaxPos), 1'b1, ident});
      rows.push_back('{make_req(CMD_PREMUL, 0, 0, 0, One, 0, 0, 0, 0, 0), 1'b1, ident});
      rows.push_back('{make_req(CMD_POSTMUL, 0, 0, 0, One, 0, 0, 0, 0, 0), 1'b1, ident});
      rows.push_back('{make_req(CMD_PRODUCT, 0, 0, 0, One, 32'h11111111, 32'h22222222,
                                32'h33333333, 32'h0F0F0F0F, 0), 1'b1,
                       '{1'b0, 32'h0F0F0F0F, 32'h33333333, 32'h22222222, 32'h11111111}});
      rows.push_back('{make_req(CMD_PRODUCT, MaxPos, MaxPos, MaxPos, MaxPos, MaxPos, MaxPos,
                                MaxPos, MaxPos, 0), 1'b0, ident});
      rows.push_back('{make_req(CMD_PRODUCT, MaxNeg, MaxNeg, MaxNeg, MaxNeg, MaxNeg, MaxNeg,
                                MaxNeg, MaxNeg, 0), 1'b0, ident});
      rows.push_back('{make_req(CmdSpare7, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, ident});
      rows.push_back('{make_req(CMD_MAKE_ROT, One, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, ident});
      rows.push_back('{make_req(CMD_MAKE_ROT, 0, One, 0, 0, 0, 0, 0, 0, MaxPos), 1'b0, ident});
      rows.push_back('{make_req(CMD_MAKE_ROT, 0, 0, One, 0, 0, 0, 0, 0, MaxNeg), 1'b0, ident});
      rows.push_back('{make_req(CMD_MAKE_ROT, MaxPos, MaxNeg, MaxPos, 0, 0, 0, 0, 0,
                                32'h3243F6A9), 1'b0, ident});
      rows.push_back('{make_req(CMD_MAKE_ROT, One, MinusOne, One, 0, 0, 0, 0, 0,
                                32'hCDBC0957), 1'b0, ident});
      rows.push_back('{make_req(CMD_PREROT, 0, 0, One, 0, 0, 0, 0, 0, 32'h10000000),
                       1'b0, ident});
      rows.push_back('{make_req(CMD_POSTROT, One, 0, 0, 0, 0, 0, 0, 0, 32'hF0000000),
                       1'b0, ident});
      rows.push_back('{make_req(CMD_PREMUL, MaxPos, MaxNeg, MaxPos, MaxNeg, 0, 0, 0, 0, 0),
                       1'b0, ident});
      rows.push_back('{make_req(CMD_POSTMUL, MaxNeg, MaxPos, MaxNeg, MaxPos, 0, 0, 0, 0, 0),
                       1'b0, ident});
      rows.push_back('{make_req(CMD_PREROT, MaxNeg, MaxNeg, MaxNeg, 0, 0, 0, 0, 0, MaxPos),
                       1'b0, ident});
      rows.push_back('{make_req(CMD_POSTROT, MaxPos, MaxPos, MaxPos, 0, 0, 0, 0, 0, MaxNeg),
                       1'b0, ident});

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i]) send_request(rows[i].req, rows[i].known, rows[i].result);

      // Random part; the block backs up against a long response hold-off early on.
      for (int n = 0; n < RandomRequests; n++) begin
         if (n == 50) hold_rsp = 1'b1;
         if (n == RandomRequests - 200) calm = 1'b1;
         send_request(random_request(), 1'b0, ident);
      end
      req_tvalid <= 1'b0;

      wait_cycles = 0;
      while (expected_orients.size() != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (50) @(posedge clock);
      if (errors == 0 && expected_orients.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
